### rtl/esd_pkg.sv
// shared types and constants for the escape sequence decoder
// character codes, decoder mode encoding and result queue sizing
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

   // characters of interest
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_E      = 8'h65;
   localparam logic [7:0] CHAR_X      = 8'h78;

   // decoded control bytes
   localparam logic [7:0] BYTE_BSLASH = 8'h5C;
   localparam logic [7:0] BYTE_QUOTE  = 8'h22;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_TAB    = 8'h09;
   localparam logic [7:0] BYTE_ESC    = 8'h1B;

   localparam int ACCUM_W = 9;

   // result queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef enum logic [5:0] {
      MODE_NORMAL = 6'b000001,
      MODE_ESC    = 6'b000010,
      MODE_HEX0   = 6'b000100,
      MODE_HEX1   = 6'b001000,
      MODE_OCT1   = 6'b010000,
      MODE_OCT2   = 6'b100000
   } mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       is_end;
   } result_type;

   typedef struct packed {
      logic       last;
      result_type res;
   } entry_type;

   typedef struct packed {
      mode_type             mode;
      logic [ACCUM_W-1:0]   accum;
      logic [1:0]           count;
      result_type           r0;
      result_type           r1;
   } dec_type;

   typedef struct packed {
      logic                   room;
      logic [QUEUE_CNT_W-1:0] level;
   } queue_status_type;

endpackage

`default_nettype wire

### rtl/esd_decode.sv
// combinational decode of one character against the current escape state
// gives the next state and up to two results
// depends on esd_pkg
`timescale 1ns / 1ps
`default_nettype none

module esd_decode (
   input  wire logic [7:0]                  char_in,
   input  wire esd_pkg::mode_type           mode,
   input  wire logic [esd_pkg::ACCUM_W-1:0] accum,
   output esd_pkg::dec_type                 dec
);
   import esd_pkg::*;

   // append one result to the list
   function automatic dec_type add_result(input dec_type d, input logic [7:0] b,
                                          input logic e);
      dec_type r;
      r = d;
      if (d.count == 2'd0) begin
         r.r0.data   = b;
         r.r0.is_end = e;
      end else begin
         r.r1.data   = b;
         r.r1.is_end = e;
      end
      r.count = d.count + 2'd1;
      return r;
   endfunction

   // character handled as ordinary text
   function automatic dec_type do_plain(input dec_type d, input logic [7:0] c);
      dec_type r;
      r = d;
      if (c == CHAR_NUL) begin
         r       = add_result(r, 8'h00, 1'b1);
         r.mode  = MODE_NORMAL;
         r.accum = '0;
      end else if (c == CHAR_BSLASH) begin
         r.mode = MODE_ESC;
      end else begin
         r      = add_result(r, c, 1'b0);
         r.mode = MODE_NORMAL;
      end
      return r;
   endfunction

   logic       is_oct;
   logic       is_dec;
   logic       is_alpha_hex;
   logic       is_hex;
   logic [3:0] hex_val;

   always_comb begin
      is_oct       = char_in inside {[8'h30:8'h37]};
      is_dec       = char_in inside {[8'h30:8'h39]};
      is_alpha_hex = char_in inside {[8'h61:8'h66], [8'h41:8'h46]};
      is_hex       = is_dec || is_alpha_hex;
      // letters a-f and A-F share the low nibble pattern 1..6
      hex_val      = is_alpha_hex ? (char_in[3:0] + 4'd9) : char_in[3:0];
   end

   always_comb begin
      dec       = '0;
      dec.mode  = mode;
      dec.accum = accum;
      case (mode)
         MODE_ESC: begin
            dec.mode = MODE_NORMAL;
            case (char_in)
               CHAR_BSLASH: dec = add_result(dec, BYTE_BSLASH, 1'b0);
               CHAR_QUOTE:  dec = add_result(dec, BYTE_QUOTE, 1'b0);
               CHAR_N:      dec = add_result(dec, BYTE_LF, 1'b0);
               CHAR_R:      dec = add_result(dec, BYTE_CR, 1'b0);
               CHAR_T:      dec = add_result(dec, BYTE_TAB, 1'b0);
               CHAR_E:      dec = add_result(dec, BYTE_ESC, 1'b0);
               CHAR_X:      dec.mode = MODE_HEX0;
               default: begin
                  if (is_oct) begin
                     dec.accum = {6'd0, char_in[2:0]};
                     dec.mode  = MODE_OCT1;
                  end else begin
                     dec = do_plain(dec, char_in);
                  end
               end
            endcase
         end
         MODE_HEX0: begin
            if (is_hex) begin
               dec.accum = {5'd0, hex_val};
               dec.mode  = MODE_HEX1;
            end else begin
               dec.mode = MODE_NORMAL;
               dec      = do_plain(dec, char_in);
            end
         end
         MODE_HEX1: begin
            dec.mode = MODE_NORMAL;
            if (is_hex) begin
               dec       = add_result(dec, {accum[3:0], hex_val}, 1'b0);
               dec.accum = '0;
            end else begin
               // flush the held digit, then treat the character as text
               dec       = add_result(dec, accum[7:0], 1'b0);
               dec.accum = '0;
               dec       = do_plain(dec, char_in);
            end
         end
         MODE_OCT1: begin
            if (is_oct) begin
               dec.accum = {accum[5:0], char_in[2:0]};
               dec.mode  = MODE_OCT2;
            end else begin
               dec.mode  = MODE_NORMAL;
               dec       = add_result(dec, accum[7:0], 1'b0);
               dec.accum = '0;
               dec       = do_plain(dec, char_in);
            end
         end
         MODE_OCT2: begin
            dec.mode = MODE_NORMAL;
            if (is_oct) begin
               // third digit: keep only the low byte
               dec       = add_result(dec, {accum[4:0], char_in[2:0]}, 1'b0);
               dec.accum = '0;
            end else begin
               dec       = add_result(dec, accum[7:0], 1'b0);
               dec.accum = '0;
               dec       = do_plain(dec, char_in);
            end
         end
         default: begin
            dec.mode = MODE_NORMAL;
            dec      = do_plain(dec, char_in);
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/esd_out_queue.sv
// small register queue of decoded results, takes up to two per cycle
// and hands out one per cycle on rsp_ while rsp_tready is high
// depends on esd_pkg
`timescale 1ns / 1ps
`default_nettype none

module esd_out_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [1:0]               push_count,
   input  wire esd_pkg::result_type      push_r0,
   input  wire esd_pkg::result_type      push_r1,
   output esd_pkg::queue_status_type     status,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [7:0]                    rsp_tdata,   // byte_out
   output logic                          rsp_tuser,   // is_end
   output logic                          rsp_tlast    // last_of_step
);
   import esd_pkg::*;

   localparam logic [QUEUE_CNT_W-1:0] ROOM_LIMIT = QUEUE_CNT_W'(QUEUE_DEPTH - 2);

   entry_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] level_ff, level_in;
   logic                   pop;
   entry_type              head;

   always_comb begin
      head       = entry_ff[rd_ptr_ff];
      rsp_tvalid = (level_ff != '0);
      rsp_tdata  = head.res.data;
      rsp_tuser  = head.res.is_end;
      rsp_tlast  = head.last;
      pop        = rsp_tvalid && rsp_tready;

      wr_ptr_in  = wr_ptr_ff + QUEUE_PTR_W'(push_count);
      rd_ptr_in  = rd_ptr_ff + QUEUE_PTR_W'(pop);
      level_in   = level_ff + QUEUE_CNT_W'(push_count) - QUEUE_CNT_W'(pop);

      // accept a new request only while two slots are surely free
      status.room  = (level_ff <= ROOM_LIMIT);
      status.level = level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff].res  <= push_r0;
         entry_ff[wr_ptr_ff].last <= (push_count == 2'd1);
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + QUEUE_PTR_W'(1)].res  <= push_r1;
         entry_ff[wr_ptr_ff + QUEUE_PTR_W'(1)].last <= 1'b1;
      end
   end

endmodule

`default_nettype wire

### rtl/escape_sequence_decoder.sv
// Escape sequence decoder: turns a stream of C-style escaped characters into
// decoded bytes, one character per request on the req_ channel.
// A zero character ends the string and yields an end marker on rsp_ with
// rsp_tuser high and rsp_tdata zero. rsp_tlast marks the last result that a
// request causes; a request gives zero, one or two results.
// A result passes from the input register through decode into the result
// queue and is presented on rsp_ from there; while the queue lacks room the
// request waits in the input register.
// Throughput: one request per cycle while each gives at most one result and
// rsp_tready stays high; a request that flushes held digits and also emits a
// byte or end marker gives two results, which share the single result port.
// The four-entry result queue lets requests keep flowing while a result
// waits; req_tready drops only when fewer than two queue slots are free.
// Reset (synchronous, active high) empties the queue, drops any held
// request and returns the decoder to plain text mode with no held digits.
// When the receiver stalls, results wait in the queue and the input side
// stalls once the queue fills; no result is lost or repeated.
// Depends on esd_pkg, esd_decode and esd_out_queue.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // char_in
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // byte_out
   output logic            rsp_tuser,    // is_end
   output logic            rsp_tlast     // last_of_step
);
   import esd_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_char_ff;
   mode_type           mode_ff, mode_in;
   logic [ACCUM_W-1:0] accum_ff, accum_in;
   dec_type            dec;
   queue_status_type   q_status;
   logic               advance;
   logic [1:0]         push_count;

   esd_decode u_decode (
      .char_in (in_char_ff),
      .mode    (mode_ff),
      .accum   (accum_ff),
      .dec     (dec)
   );

   always_comb begin
      advance     = in_valid_ff && q_status.room;
      req_tready  = !in_valid_ff || advance;
      in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
      push_count  = advance ? dec.count : 2'd0;
      mode_in     = advance ? dec.mode : mode_ff;
      accum_in    = advance ? dec.accum : accum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_NORMAL;
         accum_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         accum_ff    <= accum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
      end
   end

   esd_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_r0    (dec.r0),
      .push_r1    (dec.r1),
      .status     (q_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   // a held request that cannot move keeps its character
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_char_ff))
      else $error("held request lost or changed");

   // the queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      q_status.level <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // an end marker leaves the decoder in plain text mode with no digits held
   assert property (@(posedge clock) disable iff (reset)
      advance && ((dec.count != 2'd0 && dec.r0.is_end) ||
                  (dec.count == 2'd2 && dec.r1.is_end))
      |=> mode_ff == MODE_NORMAL && accum_ff == '0)
      else $error("state not cleared after end marker");

   // results pushed into the queue are always presented on rsp_
   assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |=> rsp_tvalid)
      else $error("pushed result not presented");
`endif

endmodule

`default_nettype wire
